// ----- rtl/hrlc_pkg.sv -----
package hrlc_pkg;

  // Character codes used by the request line grammar.
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_QUES  = 8'h3F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Parser phases.
  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_DONE = 5'd1;
  localparam logic [4:0] PH_M0   = 5'd2;
  localparam logic [4:0] PH_M1   = 5'd3;
  localparam logic [4:0] PH_P0   = 5'd4;
  localparam logic [4:0] PH_PS   = 5'd5;
  localparam logic [4:0] PH_PP1  = 5'd6;
  localparam logic [4:0] PH_PP2  = 5'd7;
  localparam logic [4:0] PH_Q    = 5'd8;
  localparam logic [4:0] PH_QP1  = 5'd9;
  localparam logic [4:0] PH_QP2  = 5'd10;
  localparam logic [4:0] PH_V0   = 5'd11;
  localparam logic [4:0] PH_V1   = 5'd12;
  localparam logic [4:0] PH_V2   = 5'd13;
  localparam logic [4:0] PH_V3   = 5'd14;
  localparam logic [4:0] PH_V4   = 5'd15;
  localparam logic [4:0] PH_V5   = 5'd16;
  localparam logic [4:0] PH_V6   = 5'd17;
  localparam logic [4:0] PH_V7   = 5'd18;
  localparam logic [4:0] PH_C0   = 5'd19;
  localparam logic [4:0] PH_C1   = 5'd20;

  // Verdict codes.
  localparam logic [1:0] VERD_PEND = 2'd0;
  localparam logic [1:0] VERD_ACC  = 2'd1;
  localparam logic [1:0] VERD_REJ  = 2'd2;

  // Part tags.
  localparam logic [2:0] PART_METHOD = 3'd0;
  localparam logic [2:0] PART_SPACE  = 3'd1;
  localparam logic [2:0] PART_PATH   = 3'd2;
  localparam logic [2:0] PART_QUERY  = 3'd3;
  localparam logic [2:0] PART_VER    = 3'd4;
  localparam logic [2:0] PART_EOL    = 3'd5;
  localparam logic [2:0] PART_IGN    = 3'd6;

  localparam int OUT_W = 16;

  // Parser state carried from one item to the next.
  typedef struct packed {
    logic [4:0] phase;
    logic [3:0] major_digit;
    logic [3:0] minor_digit;
  } parse_state_t;

  // One result item.
  typedef struct packed {
    logic [1:0] verdict;
    logic [2:0] part;
    logic [3:0] version_major;
    logic [3:0] version_minor;
  } parse_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_hex_upper(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_tchar(input logic [7:0] c);
    logic sym;
    unique case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D, 8'h2E,
      8'h5E, 8'h5F, 8'h60, 8'h7C, CH_TILDE: sym = 1'b1;
      default: sym = 1'b0;
    endcase
    return is_alnum(c) || sym;
  endfunction

  // Path character without the percent escape.
  function automatic logic is_pchar_single(input logic [7:0] c);
    logic sym;
    unique case (c)
      8'h2D, 8'h2E, 8'h5F, CH_TILDE, 8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
      8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D, CH_COLON, CH_AT: sym = 1'b1;
      default: sym = 1'b0;
    endcase
    return is_alnum(c) || sym;
  endfunction

endpackage

// ----- rtl/hrlc_step.sv -----
module hrlc_step (
  input  logic [7:0]             byte_in,
  input  logic                   first,
  input  logic                   last,
  input  hrlc_pkg::parse_state_t st,
  output hrlc_pkg::parse_state_t st_nxt,
  output hrlc_pkg::parse_result_t res
);
  import hrlc_pkg::*;

  logic [4:0] ph;
  logic [4:0] nx;
  logic [3:0] maj;
  logic [3:0] mnr;
  logic       ok;
  logic [1:0] verdict;
  logic [2:0] part;
  logic [7:0] dval;

  assign dval = byte_in - CH_ZERO;

  // Grammar step: one byte against the current phase.
  always_comb begin
    ph      = first ? PH_M0 : st.phase;
    maj     = first ? 4'd0 : st.major_digit;
    mnr     = first ? 4'd0 : st.minor_digit;
    nx      = ph;
    ok      = 1'b1;
    verdict = VERD_PEND;
    part    = PART_IGN;
    unique case (ph)
      PH_M0: begin
        part = PART_METHOD;
        if (is_tchar(byte_in)) nx = PH_M1; else ok = 1'b0;
      end
      PH_M1: begin
        if (is_tchar(byte_in)) begin
          part = PART_METHOD;
        end else if (byte_in == CH_SP) begin
          part = PART_SPACE;
          nx   = PH_P0;
        end else begin
          part = PART_METHOD;
          ok   = 1'b0;
        end
      end
      PH_P0: begin
        part = PART_PATH;
        if (byte_in == CH_SLASH) nx = PH_PS; else ok = 1'b0;
      end
      PH_PS: begin
        part = PART_PATH;
        if (is_pchar_single(byte_in) || byte_in == CH_SLASH) begin
          nx = PH_PS;
        end else if (byte_in == CH_PCT) begin
          nx = PH_PP1;
        end else if (byte_in == CH_QUES) begin
          part = PART_QUERY;
          nx   = PH_Q;
        end else if (byte_in == CH_SP) begin
          part = PART_SPACE;
          nx   = PH_V0;
        end else begin
          ok = 1'b0;
        end
      end
      PH_PP1, PH_PP2: begin
        part = PART_PATH;
        if (is_hex_upper(byte_in)) nx = (ph == PH_PP1) ? PH_PP2 : PH_PS;
        else ok = 1'b0;
      end
      PH_Q: begin
        part = PART_QUERY;
        if (is_pchar_single(byte_in) || byte_in == CH_SLASH || byte_in == CH_QUES) begin
          nx = PH_Q;
        end else if (byte_in == CH_PCT) begin
          nx = PH_QP1;
        end else if (byte_in == CH_SP) begin
          part = PART_SPACE;
          nx   = PH_V0;
        end else begin
          ok = 1'b0;
        end
      end
      PH_QP1, PH_QP2: begin
        part = PART_QUERY;
        if (is_hex_upper(byte_in)) nx = (ph == PH_QP1) ? PH_QP2 : PH_Q;
        else ok = 1'b0;
      end
      PH_V0: begin
        part = PART_VER;
        if (byte_in == CH_H) nx = PH_V1; else ok = 1'b0;
      end
      PH_V1: begin
        part = PART_VER;
        if (byte_in == CH_T) nx = PH_V2; else ok = 1'b0;
      end
      PH_V2: begin
        part = PART_VER;
        if (byte_in == CH_T) nx = PH_V3; else ok = 1'b0;
      end
      PH_V3: begin
        part = PART_VER;
        if (byte_in == CH_P) nx = PH_V4; else ok = 1'b0;
      end
      PH_V4: begin
        part = PART_VER;
        if (byte_in == CH_SLASH) nx = PH_V5; else ok = 1'b0;
      end
      PH_V5: begin
        part = PART_VER;
        if (is_digit(byte_in)) begin
          maj = dval[3:0];
          nx  = PH_V6;
        end else begin
          ok = 1'b0;
        end
      end
      PH_V6: begin
        part = PART_VER;
        if (byte_in == CH_DOT) nx = PH_V7; else ok = 1'b0;
      end
      PH_V7: begin
        part = PART_VER;
        if (is_digit(byte_in)) begin
          mnr = dval[3:0];
          nx  = PH_C0;
        end else begin
          ok = 1'b0;
        end
      end
      PH_C0: begin
        part = PART_EOL;
        if (byte_in == CH_CR) nx = PH_C1; else ok = 1'b0;
      end
      PH_C1: begin
        part = PART_EOL;
        if (byte_in == CH_LF) begin
          verdict = VERD_ACC;
          nx      = PH_DONE;
        end else begin
          ok = 1'b0;
        end
      end
      // Idle or already decided: the byte is ignored.
      default: nx = ph;
    endcase

    // A failed byte, or the last byte without acceptance, rejects the line.
    if (part != PART_IGN && (!ok || (last && verdict != VERD_ACC))) begin
      verdict = VERD_REJ;
      nx      = PH_DONE;
    end
  end

  assign st_nxt.phase       = nx;
  assign st_nxt.major_digit = maj;
  assign st_nxt.minor_digit = mnr;

  assign res.verdict       = verdict;
  assign res.part          = part;
  assign res.version_major = (verdict == VERD_ACC) ? maj : 4'd0;
  assign res.version_minor = (verdict == VERD_ACC) ? mnr : 4'd0;

endmodule

// ----- rtl/http_request_line_checker.sv -----
// Checks an HTTP request line in origin form, one byte per item, and returns one
// result item per byte: a verdict (pending, accepted at the LF, rejected here), the
// part of the line the byte belongs to, and the version digits on acceptance. A byte
// with the first flag (in_tuser) restarts the parse; in_tlast marks the final byte
// available. The block sustains one item per clock while out_tready is high: each
// byte is registered, checked by a single pass of grammar logic against the
// registered parser phase, and the result is registered.
// While a result waits at the output, the input register can still take one item;
// after that in_tready stays low until the waiting result is taken.
module http_request_line_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] byte_in
  input  logic                        in_tuser,   // [0] first
  input  logic                        in_tlast,   // last
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [hrlc_pkg::OUT_W-1:0]  out_tdata   // [1:0] verdict, [4:2] part,
                                                  // [8:5] version_major,
                                                  // [12:9] version_minor, [15:13] zero
);
  import hrlc_pkg::*;

  logic          in_v_r;
  logic [7:0]    byte_r;
  logic          first_r;
  logic          last_r;
  parse_state_t  st_r;
  parse_state_t  st_nxt;
  parse_result_t res;
  logic          out_v_r;
  parse_result_t out_r;
  logic          out_free;
  logic          proc;

  // The output register is free when empty or being drained this cycle.
  assign out_free  = !out_v_r || out_tready;
  assign proc      = in_v_r && out_free;
  assign in_tready = !in_v_r || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      byte_r  <= in_tdata;
      first_r <= in_tuser;
      last_r  <= in_tlast;
    end
  end

  hrlc_step u_step (
    .byte_in (byte_r),
    .first   (first_r),
    .last    (last_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  // Parser state advances once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= PH_IDLE;
      st_r.major_digit <= 4'd0;
      st_r.minor_digit <= 4'd0;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= in_v_r;
    end
    if (proc) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_r.version_minor, out_r.version_major,
                       out_r.part, out_r.verdict};

  // An accepted line always ends on the line-end part.
  a_acc_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.verdict == VERD_ACC) |-> (out_r.part == PART_EOL))
    else $error("accept outside line end");

  // Version fields are zero unless the line is accepted.
  a_ver_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.verdict != VERD_ACC) |->
      (out_r.version_major == 4'd0 && out_r.version_minor == 4'd0))
    else $error("version reported without acceptance");

  // Ignored bytes never carry a verdict.
  a_ign_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.part == PART_IGN) |-> (out_r.verdict == VERD_PEND))
    else $error("verdict on ignored byte");

  // Any verdict leaves the parser in the decided phase.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res.verdict != VERD_PEND) |=> (st_r.phase == PH_DONE))
    else $error("parser not decided after verdict");

endmodule
